>>> rtl/core/double_ended_priority_queue_top_defines.svh
// assertion macros used by the priority queue top
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DEP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/dep_pkg.sv
// types and constants of the double-ended priority queue
package dep_pkg;

  localparam int CAPACITY  = 64;
  localparam int OCC_W     = $clog2(CAPACITY + 1);
  localparam int PRIO_W    = 32;
  localparam int CLIENT_W  = 32;
  localparam int COUNT_W   = 16;
  localparam int MODE_W    = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

  localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP_MAX = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POP_MIN = 2'd2;

  // what every cell does in the update cycle
  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_INC,
    CMD_INSERT,
    CMD_DEC_TOP,
    CMD_DEC_BOTTOM,
    CMD_SHIFT_DOWN
  } cell_cmd_t;

  typedef struct packed {
    logic [PRIO_W-1:0]   prio;
    logic [CLIENT_W-1:0] client;
    logic [COUNT_W-1:0]  count;
  } entry_t;

  typedef struct packed {
    logic                cmp_en;
    logic [PRIO_W-1:0]   cmp_prio;
    cell_cmd_t           cmd;
    logic [PRIO_W-1:0]   new_prio;
    logic [CLIENT_W-1:0] new_client;
  } cell_ctrl_t;

endpackage

>>> rtl/core/dep_cell.sv
// one cell of the sorted chain: an entry plus its compare flags
module dep_cell (
  input  logic                clk,
  input  dep_pkg::cell_ctrl_t ctrl,
  input  logic                valid,
  input  logic                is_top,
  input  logic                is_bottom,
  input  logic                left_lt,
  input  dep_pkg::entry_t     left_ent,
  input  dep_pkg::entry_t     right_ent,
  output dep_pkg::entry_t     ent,
  output logic                lt,
  output logic                eq
);

  dep_pkg::entry_t ent_r;
  dep_pkg::entry_t ent_nxt;
  logic            lt_r;
  logic            eq_r;

  always_comb begin
    ent_nxt = ent_r;
    case (ctrl.cmd)
      dep_pkg::CMD_INC: begin
        if (eq_r && ent_r.count != dep_pkg::COUNT_MAX) begin
          ent_nxt.count = ent_r.count + dep_pkg::COUNT_ONE;
        end
      end
      dep_pkg::CMD_INSERT: begin
        if (!lt_r) begin
          if (left_lt) begin
            ent_nxt.prio   = ctrl.new_prio;
            ent_nxt.client = ctrl.new_client;
            ent_nxt.count  = dep_pkg::COUNT_ONE;
          end else begin
            ent_nxt = left_ent;
          end
        end
      end
      dep_pkg::CMD_DEC_TOP: begin
        if (is_top) begin
          ent_nxt.count = ent_r.count - dep_pkg::COUNT_ONE;
        end
      end
      dep_pkg::CMD_DEC_BOTTOM: begin
        if (is_bottom) begin
          ent_nxt.count = ent_r.count - dep_pkg::COUNT_ONE;
        end
      end
      dep_pkg::CMD_SHIFT_DOWN: begin
        ent_nxt = right_ent;
      end
      default: begin
        ent_nxt = ent_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (ctrl.cmp_en) begin
      lt_r <= valid && (ent_r.prio < ctrl.cmp_prio);
      eq_r <= valid && (ent_r.prio == ctrl.cmp_prio);
    end
  end

  assign ent = ent_r;
  assign lt  = lt_r;
  assign eq  = eq_r;

endmodule

>>> rtl/core/double_ended_priority_queue_top.sv
// double-ended priority queue built as a sorted chain of entry cells
//
// entries are held in ascending priority order, one per cell, in a row of
// dep_pkg::CAPACITY cells. every operation has a compare step and an update
// step: in the cycle where start is seen with busy low the command is captured
// and each cell compares its priority with the requested one; in the following
// cycle (busy high) all cells move at once - shift up to open a slot, shift
// down to close one, or adjust a count - and any result is worked out. start
// is not taken while busy is high, so a new command is only taken once the
// update step is done. results appear on out_valid for exactly one cycle, the
// cycle after busy, and cannot be held off by the receiver. an insert causes a
// transfer only when it is dropped on a full queue; extracts always give one;
// mode 3 is ignored. the queue comes out of reset empty and needs no clearing
// pass: cells above the occupancy count are never read.
module double_ended_priority_queue_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // command channel
  input  logic                           start,
  output logic                           busy,
  input  logic [dep_pkg::MODE_W-1:0]     in_mode,
  input  logic [dep_pkg::CLIENT_W-1:0]   in_client,
  input  logic [dep_pkg::PRIO_W-1:0]     in_priority_req,
  // result channel
  output logic                           out_valid,
  output logic [dep_pkg::CLIENT_W-1:0]   out_client,
  output logic                           out_was_empty,
  output logic                           out_dropped
);

  `include "double_ended_priority_queue_top_defines.svh"

  localparam int NCELL = dep_pkg::CAPACITY;
  localparam logic [dep_pkg::OCC_W-1:0] OCC_FULL = dep_pkg::OCC_W'(NCELL);
  localparam logic [dep_pkg::OCC_W-1:0] OCC_ONE  = dep_pkg::OCC_W'(1);

  // command capture and control state
  logic                          busy_r;
  logic [dep_pkg::MODE_W-1:0]    mode_r;
  logic [dep_pkg::CLIENT_W-1:0]  client_r;
  logic [dep_pkg::PRIO_W-1:0]    prio_r;
  logic [dep_pkg::OCC_W-1:0]     occ_r;
  logic [dep_pkg::OCC_W-1:0]     occ_nxt;

  // result register
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic [dep_pkg::CLIENT_W-1:0]  out_client_r;
  logic [dep_pkg::CLIENT_W-1:0]  out_client_nxt;
  logic                          out_was_empty_r;
  logic                          out_was_empty_nxt;
  logic                          out_dropped_r;
  logic                          out_dropped_nxt;

  // cell row
  dep_pkg::cell_ctrl_t           ctrl;
  dep_pkg::cell_cmd_t            cmd;
  dep_pkg::entry_t               cell_ent [NCELL];
  logic [NCELL-1:0]              cell_lt;
  logic [NCELL-1:0]              cell_eq;
  logic [NCELL-1:0]              cell_valid;
  logic [NCELL-1:0]              cell_top;

  logic                          accept;
  logic                          found;
  logic                          full;
  logic                          empty;
  logic [dep_pkg::CLIENT_W-1:0]  top_client;
  logic [dep_pkg::COUNT_W-1:0]   top_count;

  assign accept = start && !busy_r;
  assign found  = |cell_eq;
  assign full   = (occ_r == OCC_FULL);
  assign empty  = (occ_r == '0);

  // pick out the highest valid entry with an and-or mux over the row
  always_comb begin
    top_client = '0;
    top_count  = '0;
    for (int k = 0; k < NCELL; k++) begin
      top_client = top_client | ({dep_pkg::CLIENT_W{cell_top[k]}} & cell_ent[k].client);
      top_count  = top_count  | ({dep_pkg::COUNT_W{cell_top[k]}} & cell_ent[k].count);
    end
  end

  // update-cycle decisions: cell command, occupancy and the result
  always_comb begin
    cmd               = dep_pkg::CMD_IDLE;
    occ_nxt           = occ_r;
    out_valid_nxt     = 1'b0;
    out_client_nxt    = '0;
    out_was_empty_nxt = 1'b0;
    out_dropped_nxt   = 1'b0;
    if (busy_r) begin
      unique case (mode_r)
        dep_pkg::MODE_INSERT: begin
          if (found) begin
            // repeated priority: bump its count, no transfer
            cmd = dep_pkg::CMD_INC;
          end else if (full) begin
            out_valid_nxt   = 1'b1;
            out_dropped_nxt = 1'b1;
          end else begin
            cmd     = dep_pkg::CMD_INSERT;
            occ_nxt = occ_r + OCC_ONE;
          end
        end
        dep_pkg::MODE_POP_MAX: begin
          out_valid_nxt = 1'b1;
          if (empty) begin
            out_was_empty_nxt = 1'b1;
          end else begin
            out_client_nxt = top_client;
            if (top_count > dep_pkg::COUNT_ONE) begin
              cmd = dep_pkg::CMD_DEC_TOP;
            end else begin
              // top cell simply drops out of the valid range
              occ_nxt = occ_r - OCC_ONE;
            end
          end
        end
        dep_pkg::MODE_POP_MIN: begin
          out_valid_nxt = 1'b1;
          if (empty) begin
            out_was_empty_nxt = 1'b1;
          end else begin
            out_client_nxt = cell_ent[0].client;
            if (cell_ent[0].count > dep_pkg::COUNT_ONE) begin
              cmd = dep_pkg::CMD_DEC_BOTTOM;
            end else begin
              cmd     = dep_pkg::CMD_SHIFT_DOWN;
              occ_nxt = occ_r - OCC_ONE;
            end
          end
        end
        default: begin
          cmd = dep_pkg::CMD_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    ctrl.cmp_en     = accept;
    ctrl.cmp_prio   = in_priority_req;
    ctrl.cmd        = cmd;
    ctrl.new_prio   = prio_r;
    ctrl.new_client = client_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r          <= 1'b0;
      occ_r           <= '0;
      out_valid_r     <= 1'b0;
      out_client_r    <= '0;
      out_was_empty_r <= 1'b0;
      out_dropped_r   <= 1'b0;
    end else begin
      busy_r          <= accept;
      occ_r           <= occ_nxt;
      out_valid_r     <= out_valid_nxt;
      out_client_r    <= out_client_nxt;
      out_was_empty_r <= out_was_empty_nxt;
      out_dropped_r   <= out_dropped_nxt;
    end
  end

  // command payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= in_mode;
      client_r <= in_client;
      prio_r   <= in_priority_req;
    end
  end

  // the row of cells, each wired to its two neighbours
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    localparam logic [dep_pkg::OCC_W-1:0] IDX      = dep_pkg::OCC_W'(i);
    localparam logic [dep_pkg::OCC_W-1:0] IDX_NEXT = dep_pkg::OCC_W'(i + 1);

    logic            left_lt;
    dep_pkg::entry_t left_ent;
    dep_pkg::entry_t right_ent;

    assign cell_valid[i] = (IDX < occ_r);
    assign cell_top[i]   = (IDX_NEXT == occ_r);

    if (i == 0) begin : g_first
      // the new entry goes in at the bottom when nothing sits below it
      assign left_lt  = 1'b1;
      assign left_ent = cell_ent[i];
    end else begin : g_inner
      assign left_lt  = cell_lt[i-1];
      assign left_ent = cell_ent[i-1];
    end

    if (i == NCELL - 1) begin : g_last
      assign right_ent = cell_ent[i];
    end else begin : g_below
      assign right_ent = cell_ent[i+1];
    end

    dep_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .valid     (cell_valid[i]),
      .is_top    (cell_top[i]),
      .is_bottom ((i == 0) ? 1'b1 : 1'b0),
      .left_lt   (left_lt),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .ent       (cell_ent[i]),
      .lt        (cell_lt[i]),
      .eq        (cell_eq[i])
    );
  end

  assign busy          = busy_r;
  assign out_valid     = out_valid_r;
  assign out_client    = out_client_r;
  assign out_was_empty = out_was_empty_r;
  assign out_dropped   = out_dropped_r;

  // checks on the control flow
  `DEP_ASSERT_NEXT(a_busy_one_cycle, busy_r, !busy_r, "busy held for more than one cycle")
  `DEP_ASSERT_NOW(a_result_after_update, out_valid_r, !busy_r && $past(busy_r), "result outside the update slot")
  `DEP_ASSERT_NOW(a_occ_bound, 1'b1, occ_r <= OCC_FULL, "occupancy above capacity")
  `DEP_ASSERT_NEXT(a_occ_quiet, !busy_r, $stable(occ_r), "occupancy moved with no command")
  `DEP_ASSERT_NOW(a_flag_exclusive, out_valid_r, !(out_dropped_r && out_was_empty_r), "drop and empty flags together")

endmodule
